@@ hdl/scvp_pkg.sv @@
// Shared types and constants of the S-curve velocity profile block.
// No dependencies; every file but scvp_if.sv imports this package.
package scvp_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCELERATION = 2'd2;

    // Width of the configuration registers and of the stream payloads.
    localparam int WORD_W = 32;

    // Ramp argument width and ramp quotient width (both stay below 2^31).
    localparam int U_W = 31;
    localparam int Q_W = 31;

    // How a sample is turned into a velocity.
    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_RAMP,
        MODE_SUB,
        MODE_CRUISE
    } t_mode;

    // Which ramp argument a sample uses.
    typedef enum logic [1:0] {
        SEL_T,
        SEL_X_MINUS_T,
        SEL_T_MINUS_D,
        SEL_E_MINUS_T
    } t_sel;

    // Status of the move setup unit, seen by the sample pipeline.
    typedef struct packed {
        logic busy;
        logic kill;
    } t_setup_stat;

endpackage

@@ hdl/scvp_if.sv @@
// Stream interfaces of the S-curve velocity profile block.
// Depends on nothing; one interface for each channel.
interface scvp_time_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

interface scvp_vel_if;
    logic        valid;
    logic        ready;
    logic [31:0] velocity_command;

    modport source (output valid, output velocity_command, input ready);
    modport sink   (input valid, input velocity_command, output ready);
endinterface

@@ hdl/scvp_div_stage.sv @@
// One restoring division stage of the sample pipeline: decides one quotient bit.
// Depends on scvp_pkg.
module scvp_div_stage
    import scvp_pkg::*;
#(
    parameter int XW = 49,
    parameter int RW = 80,
    parameter int SH = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  logic [RW-1:0]  i_rem,
    input  logic [Q_W-1:0] i_quo,
    input  logic [XW-1:0]  i_x,
    output logic           o_vld,
    output logic [RW-1:0]  o_rem,
    output logic [Q_W-1:0] o_quo
);

    logic [RW-1:0]  w_den;
    logic [RW-1:0]  n_rem;
    logic [Q_W-1:0] n_quo;
    logic           r_vld;
    logic [RW-1:0]  r_rem;
    logic [Q_W-1:0] r_quo;

    // Divisor aligned to this quotient bit.
    assign w_den = RW'(i_x) << SH;

    // Trial subtraction.
    always_comb begin
        if (i_rem >= w_den) begin
            n_rem = i_rem - w_den;
            n_quo = i_quo | (Q_W'(1) << SH);
        end else begin
            n_rem = i_rem;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_quo = r_quo;

endmodule

@@ hdl/scvp_setup.sv @@
// Move setup sequencer: derives peak velocity, ramp time, cruise end and cruise
// velocity from the configuration registers. Depends on scvp_pkg.
module scvp_setup
    import scvp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int XW = FRAC_BITS + 33,
    parameter int DW = FRAC_BITS + 32,
    parameter int LW = FRAC_BITS + 35
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_dist,
    input  logic [WORD_W-1:0] i_vel,
    input  logic [WORD_W-1:0] i_acc,
    output t_setup_stat       o_stat,
    output logic [XW-1:0]     o_x,
    output logic [DW-1:0]     o_dd,
    output logic [LW-1:0]     o_e4,
    output logic [LW-1:0]     o_e5,
    output logic [WORD_W-1:0] o_cruise
);

    localparam int NW   = XW;
    localparam int CW   = $clog2(NW + 1);
    localparam int HW   = XW - WORD_W;
    localparam int SUMW = WORD_W + XW + 1;

    localparam logic [3:0] ST_PROD = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_XLD  = 4'd3;
    localparam logic [3:0] ST_XDIV = 4'd4;
    localparam logic [3:0] ST_DLD  = 4'd5;
    localparam logic [3:0] ST_DDIV = 4'd6;
    localparam logic [3:0] ST_MLO  = 4'd7;
    localparam logic [3:0] ST_MHI  = 4'd8;
    localparam logic [3:0] ST_SUM  = 4'd9;
    localparam logic [3:0] ST_DONE = 4'd10;

    logic [3:0]          r_state;
    logic [CW-1:0]       r_cnt;
    logic                r_kill;
    logic [2*WORD_W-2:0] r_half;
    logic [2*WORD_W-1:0] r_vv;
    logic [WORD_W-1:0]   r_root;
    logic [WORD_W-1:0]   r_peak;
    logic [NW-1:0]       r_num;
    logic [WORD_W-1:0]   r_den;
    logic [WORD_W-1:0]   r_rem;
    logic [NW-1:0]       r_quo;
    logic [XW-1:0]       r_x;
    logic [DW-1:0]       r_dd;
    logic [2*WORD_W-1:0] r_p0;
    logic [WORD_W+HW-1:0] r_p1;
    logic [LW-1:0]       r_e4;
    logic [LW-1:0]       r_e5;
    logic [WORD_W-1:0]   r_cruise;

    logic [2*WORD_W-1:0] w_da;
    logic [WORD_W-1:0]   w_trial;
    logic [2*WORD_W-1:0] w_sq;
    logic [WORD_W:0]     w_shift;
    logic                w_ge;
    logic [SUMW-1:0]     w_sum;

    // Full product of distance and acceleration.
    assign w_da = i_dist * i_acc;

    // Square root trial bit and its square.
    assign w_trial = r_root | (WORD_W'(1) << r_cnt[4:0]);
    assign w_sq    = w_trial * w_trial;

    // Serial division step: bring down one dividend bit.
    assign w_shift = {r_rem, r_num[NW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});

    assign w_sum = SUMW'(r_p0) + (SUMW'(r_p1) << WORD_W);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PROD;
            r_kill  <= 1'b0;
        end else if (i_start) begin
            r_state <= ST_PROD;
        end else begin
            unique case (r_state)
                ST_PROD: r_state <= ST_CHK;
                ST_CHK: begin
                    r_state <= (r_half < r_vv[2*WORD_W-2:0] || r_vv[2*WORD_W-1])
                               ? ST_SQRT : ST_XLD;
                end
                ST_SQRT: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_XLD;
                    end
                end
                ST_XLD: begin
                    if (i_acc == '0 || r_peak == '0) begin
                        r_kill  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_kill  <= 1'b0;
                        r_state <= ST_XDIV;
                    end
                end
                ST_XDIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DLD;
                    end
                end
                ST_DLD: begin
                    if (r_x == '0) begin
                        r_kill  <= 1'b1;
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_DDIV;
                    end
                end
                ST_DDIV: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_MLO;
                    end
                end
                ST_MLO:  r_state <= ST_MHI;
                ST_MHI:  r_state <= ST_SUM;
                ST_SUM:  r_state <= ST_DONE;
                ST_DONE: r_state <= ST_DONE;
                default: r_state <= ST_PROD;
            endcase
        end
    end

    // Datapath of the sequencer.
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            ST_PROD: begin
                r_half <= w_da[2*WORD_W-1:1];
                r_vv   <= i_vel * i_vel;
                r_peak <= i_vel;
            end
            ST_CHK: begin
                r_root <= '0;
                r_cnt  <= CW'(WORD_W - 1);
            end
            ST_SQRT: begin
                if (w_sq <= {1'b0, r_half}) begin
                    r_root <= w_trial;
                    if (r_cnt == '0) begin
                        r_peak <= w_trial;
                    end
                end else if (r_cnt == '0) begin
                    r_peak <= r_root;
                end
                r_cnt <= r_cnt - 1'b1;
            end
            ST_XLD: begin
                r_num <= {r_peak, 1'b0, {FRAC_BITS{1'b0}}};
                r_den <= i_acc;
                r_rem <= '0;
                r_cnt <= CW'(NW - 1);
            end
            ST_XDIV, ST_DDIV: begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? WORD_W'(w_shift - {1'b0, r_den}) : w_shift[WORD_W-1:0];
                r_quo <= {r_quo[NW-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_state == ST_XDIV && r_cnt == '0) begin
                    r_x <= {r_quo[NW-2:0], w_ge};
                end
                if (r_state == ST_DDIV && r_cnt == '0) begin
                    r_dd <= DW'({r_quo[NW-2:0], w_ge});
                end
            end
            ST_DLD: begin
                r_num <= {1'b0, i_dist, {FRAC_BITS{1'b0}}};
                r_den <= r_peak;
                r_rem <= '0;
                r_cnt <= CW'(NW - 1);
            end
            ST_MLO: begin
                r_p0 <= i_acc * r_x[WORD_W-1:0];
            end
            ST_MHI: begin
                r_p1 <= i_acc * r_x[XW-1:WORD_W];
            end
            ST_SUM: begin
                r_cruise <= w_sum[FRAC_BITS+WORD_W:FRAC_BITS+1];
                r_e5     <= LW'(r_dd) + LW'(r_x);
                r_e4     <= (LW'(r_dd) << 1) + LW'(r_x);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.busy = (r_state != ST_DONE);
    assign o_stat.kill = r_kill;
    assign o_x         = r_x;
    assign o_dd        = r_dd;
    assign o_e4        = r_e4;
    assign o_e5        = r_e5;
    assign o_cruise    = r_cruise;

endmodule

@@ hdl/scvp_pipe.sv @@
// Sample pipeline: classify the time, build the ramp argument, divide and
// square it, and select the velocity. Depends on scvp_pkg, scvp_if, scvp_div_stage.
module scvp_pipe
    import scvp_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int XW = FRAC_BITS + 33,
    parameter int DW = FRAC_BITS + 32,
    parameter int LW = FRAC_BITS + 35
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    scvp_time_if.sink         i_sample,
    scvp_vel_if.source        o_velocity,
    input  t_setup_stat       i_stat,
    input  logic [WORD_W-1:0] i_acc,
    input  logic [XW-1:0]     i_x,
    input  logic [DW-1:0]     i_dd,
    input  logic [LW-1:0]     i_e4,
    input  logic [LW-1:0]     i_e5,
    input  logic [WORD_W-1:0] i_cruise
);

    localparam int PRW = WORD_W + U_W;
    localparam int RW  = XW + Q_W;
    localparam int GW  = Q_W + U_W;

    logic en;
    logic in_fire;

    // Stage 1: classification.
    logic [U_W-1:0] w_tp;
    logic [LW-1:0]  w_t1;
    logic [LW-1:0]  w_t2;
    logic           w_neg;
    t_mode          n1_mode;
    t_sel           n1_sel;
    logic           r1_vld;
    logic [U_W-1:0] r1_t;
    t_mode          r1_mode;
    t_sel           r1_sel;

    // Stage 2: ramp argument.
    logic [LW-1:0]  n2_u;
    logic           r2_vld;
    logic [U_W-1:0] r2_u;
    t_mode          r2_mode;

    // Stage 3: numerator product.
    logic           r3_vld;
    logic [PRW-1:0] r3_prod;
    logic [U_W-1:0] r3_u;
    t_mode          r3_mode;

    // Division chain.
    logic           w_vld [0:Q_W];
    logic [RW-1:0]  w_rem [0:Q_W];
    logic [Q_W-1:0] w_quo [0:Q_W];
    logic [U_W-1:0] r_du  [0:Q_W-1];
    t_mode          r_dm  [0:Q_W-1];

    // Stage 4: ramp square.
    logic           r4_vld;
    logic [GW-1:0]  r4_g;
    t_mode          r4_mode;

    // Stage 5: output.
    logic [GW-FRAC_BITS-1:0] w_g;
    logic [WORD_W-1:0]       n5_vel;
    logic                    r5_vld;
    logic [WORD_W-1:0]       r5_vel;

    // The whole pipeline moves on together unless a result is held.
    assign en             = !r5_vld || o_velocity.ready;
    assign i_sample.ready = en && !i_stat.busy;
    assign in_fire        = i_sample.valid && i_sample.ready;

    // Compare the time with the profile breakpoints.
    assign w_tp  = i_sample.sample_time[U_W-1:0];
    assign w_neg = i_sample.sample_time[WORD_W-1] || (i_sample.sample_time == '0);
    assign w_t1  = LW'(w_tp);
    assign w_t2  = LW'(w_tp) << 1;

    always_comb begin
        n1_sel = SEL_T;
        if (w_neg || i_stat.kill) begin
            n1_mode = MODE_ZERO;
        end else if (w_t2 <= LW'(i_x)) begin
            n1_mode = MODE_RAMP;
        end else if (w_t1 <= LW'(i_x)) begin
            n1_mode = MODE_SUB;
            n1_sel  = SEL_X_MINUS_T;
        end else if (w_t1 <= LW'(i_dd)) begin
            n1_mode = MODE_CRUISE;
        end else if (w_t2 <= i_e4) begin
            n1_mode = MODE_SUB;
            n1_sel  = SEL_T_MINUS_D;
        end else if (w_t1 <= i_e5) begin
            n1_mode = MODE_RAMP;
            n1_sel  = SEL_E_MINUS_T;
        end else begin
            n1_mode = MODE_ZERO;
        end
    end

    // Ramp argument for the chosen segment.
    always_comb begin
        case (r1_sel)
            SEL_T:         n2_u = LW'(r1_t);
            SEL_X_MINUS_T: n2_u = LW'(i_x) - LW'(r1_t);
            SEL_T_MINUS_D: n2_u = LW'(r1_t) - LW'(i_dd);
            SEL_E_MINUS_T: n2_u = i_e5 - LW'(r1_t);
            default:       n2_u = '0;
        endcase
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= in_fire;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= w_vld[Q_W];
            r5_vld <= r4_vld;
        end
    end

    // Payload of the front stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_t    <= w_tp;
            r1_mode <= n1_mode;
            r1_sel  <= n1_sel;
            r2_u    <= n2_u[U_W-1:0];
            r2_mode <= r1_mode;
            r3_prod <= i_acc * r2_u;
            r3_u    <= r2_u;
            r3_mode <= r2_mode;
        end
    end

    // Quotient floor(a*u / x), one bit a stage.
    assign w_vld[0] = r3_vld;
    assign w_rem[0] = RW'(r3_prod);
    assign w_quo[0] = '0;

    for (genvar k = 0; k < Q_W; k++) begin : g_div
        scvp_div_stage #(
            .XW (XW),
            .RW (RW),
            .SH (Q_W - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .i_x     (i_x),
            .o_vld   (w_vld[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1])
        );

        // Side band travelling with the division.
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_du[k] <= r3_u;
                    r_dm[k] <= r3_mode;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_du[k] <= r_du[k-1];
                    r_dm[k] <= r_dm[k-1];
                end
            end
        end
    end

    // Ramp value before scaling.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_g    <= w_quo[Q_W] * r_du[Q_W-1];
            r4_mode <= r_dm[Q_W-1];
        end
    end

    // Select the velocity; differences saturate at zero.
    assign w_g = r4_g[GW-1:FRAC_BITS];

    always_comb begin
        case (r4_mode)
            MODE_RAMP:   n5_vel = w_g[WORD_W-1:0];
            MODE_SUB: begin
                if ((GW-FRAC_BITS)'(i_cruise) > w_g) begin
                    n5_vel = i_cruise - w_g[WORD_W-1:0];
                end else begin
                    n5_vel = '0;
                end
            end
            MODE_CRUISE: n5_vel = i_cruise;
            default:     n5_vel = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_vel <= n5_vel;
        end
    end

    assign o_velocity.valid            = r5_vld;
    assign o_velocity.velocity_command = r5_vel;

endmodule

@@ hdl/s_curve_velocity_profile.sv @@
// S-curve velocity profile: one velocity beat for each time beat.
// Pipelined through the 31-stage ramp divider; one beat accepted per cycle unless
// setup is busy or a result is held. After reset and after every register write
// the setup sequencer runs again; ready stays low meanwhile.
// Reset is synchronous, active low: registers return to 1.0 and the pipeline empties.
// Depends on scvp_pkg, scvp_if, scvp_setup, scvp_pipe.
module s_curve_velocity_profile
    import scvp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    scvp_time_if.sink            i_sample,
    scvp_vel_if.source           o_velocity,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    localparam int XW = FRAC_BITS + 33;
    localparam int DW = FRAC_BITS + 32;
    localparam int LW = FRAC_BITS + 35;
    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

    logic [WORD_W-1:0] r_dist;
    logic [WORD_W-1:0] r_vel;
    logic [WORD_W-1:0] r_acc;
    t_setup_stat       w_stat;
    logic [XW-1:0]     w_x;
    logic [DW-1:0]     w_dd;
    logic [LW-1:0]     w_e4;
    logic [LW-1:0]     w_e5;
    logic [WORD_W-1:0] w_cruise;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist <= ONE;
            r_vel  <= ONE;
            r_acc  <= ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_DISTANCE:     r_dist <= i_cfg_data;
                REG_VELOCITY:     r_vel  <= i_cfg_data;
                REG_ACCELERATION: r_acc  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Derived move values.
    scvp_setup #(
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW),
        .DW        (DW),
        .LW        (LW)
    ) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cfg_we),
        .i_dist   (r_dist),
        .i_vel    (r_vel),
        .i_acc    (r_acc),
        .o_stat   (w_stat),
        .o_x      (w_x),
        .o_dd     (w_dd),
        .o_e4     (w_e4),
        .o_e5     (w_e5),
        .o_cruise (w_cruise)
    );

    // Per-sample evaluation.
    scvp_pipe #(
        .FRAC_BITS (FRAC_BITS),
        .XW        (XW),
        .DW        (DW),
        .LW        (LW)
    ) u_pipe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (i_sample),
        .o_velocity (o_velocity),
        .i_stat     (w_stat),
        .i_acc      (r_acc),
        .i_x        (w_x),
        .i_dd       (w_dd),
        .i_e4       (w_e4),
        .i_e5       (w_e5),
        .i_cruise   (w_cruise)
    );

endmodule
